>>> design/tsq_pkg.sv
package tsq_pkg;

  // operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  localparam int STAMP_W = 31;
  localparam int ID_W    = 8;
  localparam int POS_W   = 4;
  localparam int OCC_W   = 5;

  // command broadcast to every cell for one operation
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [STAMP_W-1:0] stamp;
    logic [ID_W-1:0]    own;
    logic [ID_W-1:0]    peer;
  } cell_cmd_t;

  // flags rippling from cell i to cell i+1
  typedef struct packed {
    logic ahead;       // new request orders before this entry, or this cell is empty
    logic seen;        // a remove match occurred at or below this cell
    logic own_found;   // own id seen at or below this cell
    logic peer_found;  // peer id seen at or below this cell
  } cell_link_t;

endpackage

>>> design/tsq_cell.sv
module tsq_cell
  import tsq_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic               occ,
  input  logic [STAMP_W-1:0] prev_stamp,
  input  logic [ID_W-1:0]    prev_owner,
  input  logic [STAMP_W-1:0] next_stamp,
  input  logic [ID_W-1:0]    next_owner,
  input  cell_link_t         link_in,
  input  logic [IDX_W-1:0]   own_pos_in,
  input  logic [IDX_W-1:0]   peer_pos_in,
  output cell_link_t         link_out,
  output logic [IDX_W-1:0]   own_pos_out,
  output logic [IDX_W-1:0]   peer_pos_out,
  output logic [STAMP_W-1:0] stamp,
  output logic [ID_W-1:0]    owner
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic new_first;
  logic own_hit;
  logic peer_hit;
  logic before_here;

  // compare the held entry with the request and both ids
  always_comb begin
    if (cmd.stamp != stamp) begin
      new_first = cmd.stamp < stamp;
    end else begin
      new_first = cmd.own < owner;
    end
    before_here = !occ || new_first;
    own_hit     = occ && (owner == cmd.own);
    peer_hit    = occ && (owner == cmd.peer);
  end

  // chain outputs toward the next cell
  always_comb begin
    link_out.ahead      = before_here;
    link_out.seen       = link_in.seen || own_hit;
    link_out.own_found  = link_in.own_found || own_hit;
    link_out.peer_found = link_in.peer_found || peer_hit;
    own_pos_out         = own_hit ? MY_IDX : own_pos_in;
    peer_pos_out        = peer_hit ? MY_IDX : peer_pos_in;
  end

  // entry storage: keep, take the new request, or shift from a neighbor
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (link_in.ahead) begin
        stamp <= prev_stamp;
        owner <= prev_owner;
      end else if (before_here) begin
        stamp <= cmd.stamp;
        owner <= cmd.own;
      end
    end else if (cmd.rem && (link_in.seen || own_hit)) begin
      stamp <= next_stamp;
      owner <= next_owner;
    end
  end

endmodule

>>> design/timestamp_ordered_request_queue.sv
// Sorted request queue of up to QUEUE_DEPTH (stamp, id) entries kept in
// ascending stamp order, ties by lower id, as a row of cells that each hold one
// entry and shift left or right together. Insert, remove and find are decided
// combinationally in the cell row; the result is registered, so one beat is
// accepted per cycle while the result side keeps up, and in_ready drops only
// while a result waits on out_ready. An insert into a full queue is dropped
// with status full; a remove of an absent id gives status not found; find
// reports the last position of each id. Positions and occupancy are the low
// bits of the internal values. No clearing pass after reset.
module timestamp_ordered_request_queue
  import tsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [ID_W-1:0]    own_id,
  input  logic [ID_W-1:0]    peer_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               own_found,
  output logic [POS_W-1:0]   own_position,
  output logic               peer_found,
  output logic [POS_W-1:0]   peer_position,
  output logic [OCC_W-1:0]   occupancy
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             fire;
  logic             full;
  opcode_t          op;
  cell_cmd_t        cmd;

  logic [STAMP_W-1:0] cell_stamp [QUEUE_DEPTH];
  logic [ID_W-1:0]    cell_owner [QUEUE_DEPTH];
  cell_link_t         link       [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]   own_pos    [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]   peer_pos   [QUEUE_DEPTH+1];

  logic [1:0]           status_next;
  logic [IDX_W+POS_W-1:0] own_pos_ext;
  logic [IDX_W+POS_W-1:0] peer_pos_ext;
  logic [CNT_W+OCC_W-1:0] count_ext;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign op       = opcode_t'(opcode);
  assign full     = (count == FULL_CNT);

  // command to the cell row
  always_comb begin
    cmd.ins   = fire && (op == OP_INSERT) && !full;
    cmd.rem   = fire && (op == OP_REMOVE);
    cmd.stamp = stamp;
    cmd.own   = own_id;
    cmd.peer  = peer_id;
  end

  // chain head
  assign link[0]     = '0;
  assign own_pos[0]  = '0;
  assign peer_pos[0] = '0;

  // cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [STAMP_W-1:0] p_stamp;
    logic [ID_W-1:0]    p_owner;
    logic [STAMP_W-1:0] n_stamp;
    logic [ID_W-1:0]    n_owner;
    logic               occ;

    if (i == 0) begin : g_first
      assign p_stamp = '0;
      assign p_owner = '0;
    end else begin : g_mid
      assign p_stamp = cell_stamp[i-1];
      assign p_owner = cell_owner[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_stamp = '0;
      assign n_owner = '0;
    end else begin : g_rest
      assign n_stamp = cell_stamp[i+1];
      assign n_owner = cell_owner[i+1];
    end
    assign occ = (CNT_W'(i) < count);

    tsq_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .occ          (occ),
      .prev_stamp   (p_stamp),
      .prev_owner   (p_owner),
      .next_stamp   (n_stamp),
      .next_owner   (n_owner),
      .link_in      (link[i]),
      .own_pos_in   (own_pos[i]),
      .peer_pos_in  (peer_pos[i]),
      .link_out     (link[i+1]),
      .own_pos_out  (own_pos[i+1]),
      .peer_pos_out (peer_pos[i+1]),
      .stamp        (cell_stamp[i]),
      .owner        (cell_owner[i])
    );
  end

  // fill count and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (link[QUEUE_DEPTH].seen) begin
          count_next = count - 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_FIND, OP_NONE: begin
        count_next = count;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign own_pos_ext  = {{POS_W{1'b0}}, own_pos[QUEUE_DEPTH]};
  assign peer_pos_ext = {{POS_W{1'b0}}, peer_pos[QUEUE_DEPTH]};
  assign count_ext    = {{OCC_W{1'b0}}, count_next};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      status    <= status_next;
      occupancy <= count_ext[OCC_W-1:0];
      if (op == OP_FIND) begin
        own_found     <= link[QUEUE_DEPTH].own_found;
        own_position  <= link[QUEUE_DEPTH].own_found ? own_pos_ext[POS_W-1:0] : '0;
        peer_found    <= link[QUEUE_DEPTH].peer_found;
        peer_position <= link[QUEUE_DEPTH].peer_found ? peer_pos_ext[POS_W-1:0] : '0;
      end else begin
        own_found     <= 1'b0;
        own_position  <= '0;
        peer_found    <= 1'b0;
        peer_position <= '0;
      end
    end
  end

endmodule

>>> design/tsq_checker.sv
module tsq_checker
  import tsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic             own_found,
  input logic [POS_W-1:0] own_position,
  input logic             peer_found,
  input logic [POS_W-1:0] peer_position,
  input logic [OCC_W-1:0] occupancy
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
    else $error("result changed while stalled");

  // every accepted beat yields a result the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat without result");

  // a dropped insert reports a full queue
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> occupancy == FULL_OCC)
    else $error("full status with partial occupancy");

  // positions are zero unless the id was found
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (own_found || own_position == '0) && (peer_found || peer_position == '0))
    else $error("position given for absent id");

endmodule

bind timestamp_ordered_request_queue tsq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tsq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .own_found     (own_found),
  .own_position  (own_position),
  .peer_found    (peer_found),
  .peer_position (peer_position),
  .occupancy     (occupancy)
);
